// ===== rtl/yrx_pkg.sv =====
// ----------------------------------------------------------------------------
// yrx_pkg
// Shared types, protocol codes and the CRC-16/XMODEM byte update for the
// YMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package yrx_pkg;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_WAIT_START = 4'd1,
        PH_NUM        = 4'd2,
        PH_INV        = 4'd3,
        PH_DATA       = 4'd4,
        PH_CRCH       = 4'd5,
        PH_CRCL       = 4'd6,
        PH_WAIT_NEXT  = 4'd7,
        PH_EOT2       = 4'd8,
        PH_FINAL      = 4'd9,
        PH_DRAIN      = 4'd10
    } t_phase;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [2:0] K_SEND    = 3'd0;
    localparam logic [2:0] K_STAGE   = 3'd1;
    localparam logic [2:0] K_COMMIT  = 3'd2;
    localparam logic [2:0] K_DISCARD = 3'd3;
    localparam logic [2:0] K_FINISH  = 3'd4;

    localparam logic [2:0] CFG_BASE     = 3'd0;
    localparam logic [2:0] CFG_END      = 3'd1;
    localparam logic [2:0] CFG_START_TO = 3'd2;
    localparam logic [2:0] CFG_HDR_TO   = 3'd3;
    localparam logic [2:0] CFG_BYTE_TO  = 3'd4;
    localparam logic [2:0] CFG_NEXT_TO  = 3'd5;
    localparam logic [2:0] CFG_RETRY    = 3'd6;

    localparam logic [10:0] SHORT_LEN = 11'd128;
    localparam logic [7:0]  DRAIN_LEN = 8'd132;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  INV_MASK  = 8'hFF;
    localparam logic [11:0] TIMER_MAX = 12'hFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [9:0]  offset;
        logic [31:0] addr;
        logic [10:0] len;
        logic        success;
    } t_res;

    // room for four results; one input beat causes at most three
    typedef struct packed {
        t_res [3:0] res;
        logic [2:0] cnt;
    } t_bundle;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else       c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/yrx_front.sv =====
// ----------------------------------------------------------------------------
// yrx_front
// Protocol engine: takes one event a cycle while the result queue is not full,
// updates session state and builds the bundle of results that the event causes.
// ----------------------------------------------------------------------------
module yrx_front #(
    parameter int LONG_BLOCK_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output yrx_pkg::t_bundle  o_bundle
);

    logic [31:0] r_base, r_end;
    logic [11:0] r_start_to, r_hdr_to, r_byte_to, r_next_to;
    logic [5:0]  r_retry;

    yrx_pkg::t_phase r_phase, n_phase;
    logic [5:0]  r_attempt, n_attempt;
    logic [11:0] r_timer, n_timer;
    logic [7:0]  r_expected, n_expected;
    logic        r_started, n_started;
    logic [31:0] r_nwa, n_nwa;
    logic [7:0]  r_blknum, n_blknum;
    logic        r_long, n_long;
    logic [10:0] r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crch, n_crch;
    logic [7:0]  r_drain, n_drain;

    logic        w_acc, w_start, w_byte, w_tick, w_tout, w_fail_end;
    logic        w_first, w_expect, w_fits, w_crc_ok, w_hdr_ok;
    logic [11:0] w_timer_inc, w_limit;
    logic [5:0]  w_att_inc;
    logic [10:0] w_blen, w_idx_inc;
    logic [7:0]  w_drain_inc;
    logic [15:0] w_crc_next;
    logic [32:0] w_end_sum;
    yrx_pkg::t_bundle w_b;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_start = w_acc && (i_action == yrx_pkg::ACT_START);
    assign w_byte  = w_acc && (i_action == yrx_pkg::ACT_BYTE);
    assign w_tick  = w_acc && (i_action == yrx_pkg::ACT_TICK) && (r_phase != yrx_pkg::PH_IDLE);

    assign w_timer_inc = (r_timer == yrx_pkg::TIMER_MAX) ? r_timer : r_timer + 12'd1;

    always_comb begin
        case (r_phase)
            yrx_pkg::PH_WAIT_START, yrx_pkg::PH_FINAL: w_limit = r_start_to;
            yrx_pkg::PH_NUM, yrx_pkg::PH_INV, yrx_pkg::PH_EOT2: w_limit = r_hdr_to;
            yrx_pkg::PH_WAIT_NEXT: w_limit = r_next_to;
            default: w_limit = r_byte_to;
        endcase
    end

    assign w_tout      = w_tick && (w_timer_inc >= w_limit);
    assign w_att_inc   = r_attempt + 6'd1;
    assign w_fail_end  = w_att_inc >= r_retry;
    assign w_blen      = r_long ? 11'(LONG_BLOCK_BYTES) : yrx_pkg::SHORT_LEN;
    assign w_idx_inc   = r_idx + 11'd1;
    assign w_drain_inc = r_drain + 8'd1;
    assign w_crc_next  = yrx_pkg::crc_byte(r_crc, i_rx_byte);
    assign w_crc_ok    = ({r_crch, i_rx_byte} == r_crc);
    assign w_hdr_ok    = ((r_blknum ^ i_rx_byte) == yrx_pkg::INV_MASK);
    assign w_first     = (r_blknum == 8'd0) && !r_started;
    assign w_expect    = (r_blknum == r_expected);
    assign w_end_sum   = {1'b0, r_nwa} + {22'd0, w_blen};
    assign w_fits      = w_end_sum <= {1'b0, r_end};

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_attempt  = r_attempt;
        n_timer    = r_timer;
        n_expected = r_expected;
        n_started  = r_started;
        n_nwa      = r_nwa;
        n_blknum   = r_blknum;
        n_long     = r_long;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_crch     = r_crch;
        n_drain    = r_drain;
        if (w_start) begin
            n_attempt  = 6'd0;
            n_expected = 8'd0;
            n_started  = 1'b0;
            n_nwa      = r_base;
            n_phase    = yrx_pkg::PH_WAIT_START;
            n_timer    = 12'd0;
        end else if (w_byte) begin
            n_timer = 12'd0;
            case (r_phase)
                yrx_pkg::PH_WAIT_START, yrx_pkg::PH_WAIT_NEXT: begin
                    if (i_rx_byte == yrx_pkg::B_SOH || i_rx_byte == yrx_pkg::B_STX) begin
                        n_long  = (i_rx_byte == yrx_pkg::B_STX);
                        n_phase = yrx_pkg::PH_NUM;
                    end else if (i_rx_byte == yrx_pkg::B_EOT) begin
                        n_phase = yrx_pkg::PH_EOT2;
                    end else if (i_rx_byte == yrx_pkg::B_CAN) begin
                        n_phase = yrx_pkg::PH_IDLE;
                    end else begin
                        n_attempt = w_att_inc;
                        n_phase   = w_fail_end ? yrx_pkg::PH_IDLE : yrx_pkg::PH_WAIT_START;
                    end
                end
                yrx_pkg::PH_NUM: begin
                    n_blknum = i_rx_byte;
                    n_phase  = yrx_pkg::PH_INV;
                end
                yrx_pkg::PH_INV: begin
                    if (!w_hdr_ok) begin
                        n_attempt = w_att_inc;
                        n_phase   = w_fail_end ? yrx_pkg::PH_IDLE : yrx_pkg::PH_WAIT_START;
                    end else begin
                        n_idx   = 11'd0;
                        n_crc   = 16'd0;
                        n_phase = yrx_pkg::PH_DATA;
                    end
                end
                yrx_pkg::PH_DATA: begin
                    n_crc = w_crc_next;
                    n_idx = w_idx_inc;
                    if (w_idx_inc >= w_blen) n_phase = yrx_pkg::PH_CRCH;
                end
                yrx_pkg::PH_CRCH: begin
                    n_crch  = i_rx_byte;
                    n_phase = yrx_pkg::PH_CRCL;
                end
                yrx_pkg::PH_CRCL: begin
                    if (!w_crc_ok) begin
                        n_attempt = w_att_inc;
                        n_phase   = w_fail_end ? yrx_pkg::PH_IDLE : yrx_pkg::PH_WAIT_START;
                    end else begin
                        if (w_first) begin
                            n_started  = 1'b1;
                            n_expected = 8'd1;
                        end else if (w_expect) begin
                            if (w_fits) n_nwa = w_end_sum[31:0];
                            n_expected = r_expected + 8'd1;
                        end
                        n_phase = yrx_pkg::PH_WAIT_NEXT;
                    end
                end
                yrx_pkg::PH_EOT2: n_phase = yrx_pkg::PH_FINAL;
                yrx_pkg::PH_FINAL: begin
                    if (i_rx_byte == yrx_pkg::B_SOH) begin
                        n_drain = 8'd0;
                        n_phase = yrx_pkg::PH_DRAIN;
                    end else begin
                        n_phase = yrx_pkg::PH_IDLE;
                    end
                end
                yrx_pkg::PH_DRAIN: begin
                    n_drain = w_drain_inc;
                    if (w_drain_inc >= yrx_pkg::DRAIN_LEN) n_phase = yrx_pkg::PH_IDLE;
                end
                default: ;
            endcase
        end else if (w_tick) begin
            n_timer = w_tout ? 12'd0 : w_timer_inc;
            if (w_tout) begin
                case (r_phase)
                    yrx_pkg::PH_EOT2: n_phase = yrx_pkg::PH_FINAL;
                    yrx_pkg::PH_FINAL, yrx_pkg::PH_DRAIN: n_phase = yrx_pkg::PH_IDLE;
                    yrx_pkg::PH_WAIT_START, yrx_pkg::PH_WAIT_NEXT, yrx_pkg::PH_NUM,
                    yrx_pkg::PH_INV, yrx_pkg::PH_DATA, yrx_pkg::PH_CRCH,
                    yrx_pkg::PH_CRCL: begin
                        n_attempt = w_att_inc;
                        n_phase   = w_fail_end ? yrx_pkg::PH_IDLE : yrx_pkg::PH_WAIT_START;
                    end
                    default: n_phase = yrx_pkg::PH_IDLE;
                endcase
            end
        end
    end

    function automatic yrx_pkg::t_res mk(input logic [2:0] kind, input logic [7:0] value,
                                         input logic succ);
        yrx_pkg::t_res r;
        r         = '0;
        r.kind    = kind;
        r.value   = value;
        r.success = succ;
        return r;
    endfunction

    // result bundle
    always_comb begin
        yrx_pkg::t_res rs;
        logic in_blk;
        logic do_fail;
        w_b     = '0;
        rs      = '0;
        do_fail = 1'b0;
        in_blk  = (r_phase == yrx_pkg::PH_DATA) || (r_phase == yrx_pkg::PH_CRCH) ||
                  (r_phase == yrx_pkg::PH_CRCL);
        if (w_start) begin
            if (in_blk) begin
                w_b.res[w_b.cnt[1:0]] = mk(yrx_pkg::K_DISCARD, 8'd0, 1'b0);
                w_b.cnt = w_b.cnt + 3'd1;
            end
            w_b.res[w_b.cnt[1:0]] = mk(yrx_pkg::K_SEND, yrx_pkg::B_C, 1'b0);
            w_b.cnt = w_b.cnt + 3'd1;
        end else if (w_byte) begin
            case (r_phase)
                yrx_pkg::PH_WAIT_START, yrx_pkg::PH_WAIT_NEXT: begin
                    if (i_rx_byte == yrx_pkg::B_SOH || i_rx_byte == yrx_pkg::B_STX) begin
                    end else if (i_rx_byte == yrx_pkg::B_EOT) begin
                        w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_NAK, 1'b0);
                        w_b.cnt    = 3'd1;
                    end else if (i_rx_byte == yrx_pkg::B_CAN) begin
                        w_b.res[0] = mk(yrx_pkg::K_FINISH, 8'd0, 1'b0);
                        w_b.cnt    = 3'd1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                yrx_pkg::PH_INV: begin
                    if (!w_hdr_ok) begin
                        w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_NAK, 1'b0);
                        w_b.cnt    = 3'd1;
                        do_fail    = 1'b1;
                    end
                end
                yrx_pkg::PH_DATA: begin
                    rs         = mk(yrx_pkg::K_STAGE, i_rx_byte, 1'b0);
                    rs.offset  = r_idx[9:0];
                    w_b.res[0] = rs;
                    w_b.cnt    = 3'd1;
                end
                yrx_pkg::PH_CRCL: begin
                    if (!w_crc_ok) begin
                        w_b.res[0] = mk(yrx_pkg::K_DISCARD, 8'd0, 1'b0);
                        w_b.res[1] = mk(yrx_pkg::K_SEND, yrx_pkg::B_NAK, 1'b0);
                        w_b.cnt    = 3'd2;
                        do_fail    = 1'b1;
                    end else if (w_first) begin
                        w_b.res[0] = mk(yrx_pkg::K_DISCARD, 8'd0, 1'b0);
                        w_b.res[1] = mk(yrx_pkg::K_SEND, yrx_pkg::B_ACK, 1'b0);
                        w_b.res[2] = mk(yrx_pkg::K_SEND, yrx_pkg::B_C, 1'b0);
                        w_b.cnt    = 3'd3;
                    end else begin
                        if (w_expect && w_fits) begin
                            rs      = mk(yrx_pkg::K_COMMIT, 8'd0, 1'b0);
                            rs.addr = r_nwa;
                            rs.len  = w_blen;
                        end else begin
                            rs = mk(yrx_pkg::K_DISCARD, 8'd0, 1'b0);
                        end
                        w_b.res[0] = rs;
                        w_b.res[1] = mk(yrx_pkg::K_SEND, yrx_pkg::B_ACK, 1'b0);
                        w_b.cnt    = 3'd2;
                    end
                end
                yrx_pkg::PH_EOT2: begin
                    w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_ACK, 1'b0);
                    w_b.res[1] = mk(yrx_pkg::K_SEND, yrx_pkg::B_C, 1'b0);
                    w_b.cnt    = 3'd2;
                end
                yrx_pkg::PH_FINAL: begin
                    if (i_rx_byte != yrx_pkg::B_SOH) begin
                        w_b.res[0] = mk(yrx_pkg::K_FINISH, 8'd0, 1'b1);
                        w_b.cnt    = 3'd1;
                    end
                end
                yrx_pkg::PH_DRAIN: begin
                    if (w_drain_inc >= yrx_pkg::DRAIN_LEN) begin
                        w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_ACK, 1'b0);
                        w_b.res[1] = mk(yrx_pkg::K_FINISH, 8'd0, 1'b1);
                        w_b.cnt    = 3'd2;
                    end
                end
                default: ;
            endcase
        end else if (w_tout) begin
            case (r_phase)
                yrx_pkg::PH_WAIT_START, yrx_pkg::PH_WAIT_NEXT: do_fail = 1'b1;
                yrx_pkg::PH_NUM, yrx_pkg::PH_INV: begin
                    w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_NAK, 1'b0);
                    w_b.cnt    = 3'd1;
                    do_fail    = 1'b1;
                end
                yrx_pkg::PH_DATA, yrx_pkg::PH_CRCH, yrx_pkg::PH_CRCL: begin
                    w_b.res[0] = mk(yrx_pkg::K_DISCARD, 8'd0, 1'b0);
                    w_b.res[1] = mk(yrx_pkg::K_SEND, yrx_pkg::B_NAK, 1'b0);
                    w_b.cnt    = 3'd2;
                    do_fail    = 1'b1;
                end
                yrx_pkg::PH_EOT2: begin
                    w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_ACK, 1'b0);
                    w_b.res[1] = mk(yrx_pkg::K_SEND, yrx_pkg::B_C, 1'b0);
                    w_b.cnt    = 3'd2;
                end
                yrx_pkg::PH_FINAL: begin
                    w_b.res[0] = mk(yrx_pkg::K_FINISH, 8'd0, 1'b1);
                    w_b.cnt    = 3'd1;
                end
                yrx_pkg::PH_DRAIN: begin
                    w_b.res[0] = mk(yrx_pkg::K_SEND, yrx_pkg::B_ACK, 1'b0);
                    w_b.res[1] = mk(yrx_pkg::K_FINISH, 8'd0, 1'b1);
                    w_b.cnt    = 3'd2;
                end
                default: ;
            endcase
        end
        // failed attempt: retry prompt or give up
        if (do_fail) begin
            if (w_fail_end) w_b.res[w_b.cnt[1:0]] = mk(yrx_pkg::K_FINISH, 8'd0, 1'b0);
            else            w_b.res[w_b.cnt[1:0]] = mk(yrx_pkg::K_SEND, yrx_pkg::B_C, 1'b0);
            w_b.cnt = w_b.cnt + 3'd1;
        end
    end

    assign o_bundle = w_b;
    assign o_push   = w_acc && (w_b.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= 32'd134225920;
            r_end      <= 32'd134283264;
            r_start_to <= 12'd1000;
            r_hdr_to   <= 12'd500;
            r_byte_to  <= 12'd200;
            r_next_to  <= 12'd2000;
            r_retry    <= 6'd30;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                yrx_pkg::CFG_BASE:     r_base     <= i_cfg_data;
                yrx_pkg::CFG_END:      r_end      <= i_cfg_data;
                yrx_pkg::CFG_START_TO: r_start_to <= i_cfg_data[11:0];
                yrx_pkg::CFG_HDR_TO:   r_hdr_to   <= i_cfg_data[11:0];
                yrx_pkg::CFG_BYTE_TO:  r_byte_to  <= i_cfg_data[11:0];
                yrx_pkg::CFG_NEXT_TO:  r_next_to  <= i_cfg_data[11:0];
                yrx_pkg::CFG_RETRY:    r_retry    <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= yrx_pkg::PH_IDLE;
            r_attempt  <= 6'd0;
            r_timer    <= 12'd0;
            r_expected <= 8'd0;
            r_started  <= 1'b0;
            r_nwa      <= 32'd134225920;
            r_blknum   <= 8'd0;
            r_long     <= 1'b0;
            r_idx      <= 11'd0;
            r_crc      <= 16'd0;
            r_crch     <= 8'd0;
            r_drain    <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_attempt  <= n_attempt;
            r_timer    <= n_timer;
            r_expected <= n_expected;
            r_started  <= n_started;
            r_nwa      <= n_nwa;
            r_blknum   <= n_blknum;
            r_long     <= n_long;
            r_idx      <= n_idx;
            r_crc      <= n_crc;
            r_crch     <= n_crch;
            r_drain    <= n_drain;
        end
    end

endmodule

// ===== rtl/yrx_queue.sv =====
// ----------------------------------------------------------------------------
// yrx_queue
// Two-entry queue of result bundles between the protocol engine and the
// output serialiser.
// ----------------------------------------------------------------------------
module yrx_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  yrx_pkg::t_bundle  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output yrx_pkg::t_bundle  o_data
);

    yrx_pkg::t_bundle r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== rtl/yrx_back.sv =====
// ----------------------------------------------------------------------------
// yrx_back
// Output serialiser: holds one bundle and hands its results out one beat at
// a time, marking the final one.
// ----------------------------------------------------------------------------
module yrx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  yrx_pkg::t_bundle  i_q_data,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output yrx_pkg::t_res     o_res,
    output logic              o_last
);

    yrx_pkg::t_bundle r_bundle;
    logic             r_valid;
    logic [1:0]       r_idx;
    logic             w_fire, w_done;

    assign o_valid = r_valid;
    assign o_res   = r_bundle.res[r_idx];
    assign o_last  = ({1'b0, r_idx} + 3'd1) == r_bundle.cnt;
    assign w_fire  = r_valid && i_ready;
    assign w_done  = !r_valid || (w_fire && o_last);
    assign o_pop   = w_done && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_bundle <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_done) begin
            r_valid <= i_q_valid;
            r_idx   <= 2'd0;
        end else if (w_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/ymodem_crc_receiver.sv =====
// ----------------------------------------------------------------------------
// ymodem_crc_receiver
// YMODEM-CRC receiver: parses blocks, checks CRC-16/XMODEM, emits handshake
// bytes, staged payload bytes and commit/discard/finish results.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                              tuser    tlast
//  s_axis    in         rx_byte[7:0]                       action   -
//  m_axis    out        value,offset,address,length,succ   kind     last of event
//  cfg       in         i_cfg_index selects, i_cfg_data    -        -
//
//  one event is taken per cycle while the two-entry bundle queue has room
//  each event yields zero to three result beats, one beat a cycle at the output while m_axis_tready is high,
//  so sustained rate is one event per cycle for events with at most one result
//  a stalled output fills the queue and then holds s_axis_tready low
//  synchronous active-low reset; configuration is always ready
// ----------------------------------------------------------------------------
module ymodem_crc_receiver #(
    parameter int LONG_BLOCK_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value[7:0], offset[17:8], write_address[49:18], block_length[60:50],
    // success[61], zero[63:62]
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    logic             w_push, w_full, w_pop, w_q_valid;
    yrx_pkg::t_bundle w_bundle, w_q_data;
    yrx_pkg::t_res    w_res;

    assign o_cfg_ready = 1'b1;

    yrx_front #(.LONG_BLOCK_BYTES(LONG_BLOCK_BYTES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_rx_byte   (s_axis_tdata),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_bundle    (w_bundle)
    );

    yrx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_bundle),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    yrx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (w_res),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tdata = {2'b00, w_res.success, w_res.len, w_res.addr,
                           w_res.offset, w_res.value};

endmodule
